>>> design/astf_pkg.sv
package astf_pkg;

    localparam int MAX_LEVELS = 16;
    localparam int LEVELS_DEF = 10;
    localparam int IDX_W      = MAX_LEVELS;

    localparam logic       REQ_INSERT  = 1'b0;
    localparam logic       REQ_FIND    = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP_MISS = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] key;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [9:0] slot;
        logic [1:0] status;
    } t_rsp;

    // request walking down the chain of level cells
    typedef struct packed {
        logic             valid;
        logic             done;
        logic             is_find;
        logic [7:0]       key;
        logic [IDX_W-1:0] idx;    // index within the current level
        t_rsp             rsp;
    } t_tok;

endpackage

>>> design/array_search_tree_insert_find_core.sv
// Binary search tree of 8-bit keys in an implicit array (children of slot i
// at 2i+1 and 2i+2, zero means empty). Each word on the request channel
// inserts or looks up a key; each gives one response word (found, slot,
// status). The store is split into one cell per tree level, and a request
// walks down the chain one level per cycle; the block takes no new request
// until the previous one has left the last level. One request is in the chain
// at a time; a finished response waits in an output register plus a hold
// register, so the next request is taken while the previous response is still
// stalled. After reset the store is swept clear with request stall held high.
module array_search_tree_insert_find_core #(
    parameter int LEVELS = astf_pkg::LEVELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  astf_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output astf_pkg::t_rsp o_rsp
);
    import astf_pkg::*;

    localparam int CW = (LEVELS > 1) ? LEVELS - 1 : 1;
    localparam logic [CW-1:0] CLR_LAST = CW'((1 << (LEVELS - 1)) - 1);

    t_tok w_tok [0:LEVELS];

    logic          r_clr;      // clearing sweep after reset
    logic [CW-1:0] r_clr_cnt;
    logic          r_busy;     // a request is in the chain
    logic          r_out_v;
    t_rsp          r_out;
    logic          r_hold_v;
    t_rsp          r_hold;

    logic w_acc;
    logic w_take;
    logic w_exit;
    t_rsp w_res;

    assign o_stall = r_clr || r_busy || r_hold_v;
    assign w_acc   = i_valid && !o_stall;
    assign w_take  = r_out_v && !i_stall;

    // injection into the first cell; a zero key rides the chain already done
    always_comb begin
        w_tok[0].valid   = w_acc;
        w_tok[0].done    = (i_req.key == 8'd0);
        w_tok[0].is_find = (i_req.req_type == REQ_FIND);
        w_tok[0].key     = i_req.key;
        w_tok[0].idx     = '0;
        w_tok[0].rsp     = '{found: 1'b0, slot: 10'd0, status: ST_ZERO};
    end

    for (genvar g = 0; g < LEVELS; g++) begin : g_level
        astf_cell #(
            .LEVEL (g),
            .CW    (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clr     (r_clr),
            .i_clr_addr(r_clr_cnt),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1])
        );
    end

    // a walk that leaves the last level without a decision ran out of depth
    assign w_exit = w_tok[LEVELS].valid;
    always_comb begin
        if (w_tok[LEVELS].done) begin
            w_res = w_tok[LEVELS].rsp;
        end else begin
            w_res = '{found: 1'b0, slot: 10'd0, status: ST_FULL};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_clr) begin
            if (r_clr_cnt == CLR_LAST) begin
                r_clr <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_acc) begin
            r_busy <= 1'b1;
        end else if (w_exit) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (w_exit) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
                r_out   <= w_res;
            end else begin
                r_hold_v <= 1'b1;
                r_hold   <= w_res;
            end
        end else if (w_take) begin
            if (r_hold_v) begin
                r_out    <= r_hold;
                r_hold_v <= 1'b0;
            end else begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

endmodule

>>> design/astf_cell.sv
module astf_cell #(
    parameter int LEVEL  = 0,
    parameter int CW     = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clr,
    input  logic [CW-1:0]  i_clr_addr,
    input  astf_pkg::t_tok i_tok,
    output astf_pkg::t_tok o_tok
);
    import astf_pkg::*;

    localparam int IW    = (LEVEL == 0) ? 1 : LEVEL;
    localparam int DEPTH = 1 << LEVEL;
    localparam logic [IDX_W-1:0] BASE = IDX_W'(DEPTH - 1);

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rd;
    t_tok       r_tok;
    t_tok       n_tok;
    logic       w_wr;
    logic [IDX_W-1:0] w_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.done    <= i_tok.done;
        r_tok.is_find <= i_tok.is_find;
        r_tok.key     <= i_tok.key;
        r_tok.idx     <= i_tok.idx;
        r_tok.rsp     <= i_tok.rsp;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_tok.idx[IW-1:0]];
        if (i_clr) begin
            r_mem[i_clr_addr[IW-1:0]] <= 8'd0;
        end else if (w_wr) begin
            r_mem[r_tok.idx[IW-1:0]] <= r_tok.key;
        end
    end

    assign w_slot = BASE + r_tok.idx;

    always_comb begin
        n_tok = r_tok;
        w_wr  = 1'b0;
        if (r_tok.valid && !r_tok.done) begin
            if (r_rd == 8'd0) begin
                n_tok.done = 1'b1;
                if (r_tok.is_find) begin
                    n_tok.rsp = '{found: 1'b0, slot: 10'd0, status: ST_DUP_MISS};
                end else begin
                    n_tok.rsp = '{found: 1'b1, slot: w_slot[9:0], status: ST_OK};
                    w_wr      = 1'b1;
                end
            end else if (r_rd == r_tok.key) begin
                n_tok.done = 1'b1;
                n_tok.rsp  = '{found: 1'b1, slot: w_slot[9:0],
                               status: r_tok.is_find ? ST_OK : ST_DUP_MISS};
            end else begin
                // left child keeps the smaller keys
                n_tok.idx = {r_tok.idx[IDX_W-2:0], (r_tok.key >= r_rd)};
            end
        end
    end

    assign o_tok = n_tok;

endmodule

>>> design/astf_checker.sv
module astf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input astf_pkg::t_req i_req,
    input logic           o_valid,
    input logic           i_stall,
    input astf_pkg::t_rsp o_rsp
);
    import astf_pkg::*;

    // a response word that reports nothing found carries slot zero
    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.found) |-> (o_rsp.slot == 10'd0))
        else $error("miss with nonzero slot");

    // zero key and depth exhausted never report found
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_ZERO || o_rsp.status == ST_FULL))
        |-> !o_rsp.found)
        else $error("rejected word reports found");

    // an accepted request occupies the chain on the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken while another walks");

    // a stalled response word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rsp)))
        else $error("stalled response changed");

endmodule

bind array_search_tree_insert_find_core astf_checker u_astf_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .i_req  (i_req),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_rsp  (o_rsp)
);

>>> tb/array_search_tree_insert_find_core_tb.sv
`timescale 1ns / 1ps

module array_search_tree_insert_find_core_tb;
    import astf_pkg::*;

    localparam int LEVELS    = 10;
    localparam int TREE_SIZE = (1 << LEVELS) - 1;
    localparam int N_RANDOM  = 1530;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    array_search_tree_insert_find_core #(.LEVELS(LEVELS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow copy of the tree, updated as each request word is accepted
    logic [7:0] shadow_tree [TREE_SIZE];

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   mismatch_cnt;
    bit   stim_done;

    // walk the shadow tree exactly as the block does
    function automatic t_rsp walk_tree(t_req req);
        t_rsp r;
        int   pos;
        r = '0;
        pos = 0;
        if (req.key == 8'd0) begin
            r.status = ST_ZERO;
            return r;
        end
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            if (shadow_tree[pos] == 8'd0) begin
                if (req.req_type == REQ_FIND) begin
                    r.status = ST_DUP_MISS;
                end else begin
                    shadow_tree[pos] = req.key;
                    r.found  = 1'b1;
                    r.slot   = pos[9:0];
                    r.status = ST_OK;
                end
                return r;
            end
            if (shadow_tree[pos] == req.key) begin
                r.found  = 1'b1;
                r.slot   = pos[9:0];
                r.status = (req.req_type == REQ_FIND) ? ST_OK : ST_DUP_MISS;
                return r;
            end
            pos = (req.key < shadow_tree[pos]) ? 2 * pos + 1 : 2 * pos + 2;
        end
        r.status = ST_FULL;
        return r;
    endfunction

    function automatic t_req mk_req(logic rtype, logic [7:0] key);
        t_req q;
        q.req_type = rtype;
        q.key      = key;
        return q;
    endfunction

    // driver: bursts of back-to-back words separated by random gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_req      <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            automatic logic take = i_valid && !o_stall;
            automatic logic hold = i_valid && o_stall;
            if (take) begin
                expected_rsps.push_back(walk_tree(i_req));
            end
            if (!hold) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    i_req   <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0
                                                                  : $urandom_range(0, 20);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: switches at random between calm stretches and choppy ones
    int stall_mode_cnt;
    logic choppy;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall        <= 1'b0;
            stall_mode_cnt <= 0;
            choppy         <= 1'b0;
        end else begin
            if (stall_mode_cnt == 0) begin
                stall_mode_cnt <= $urandom_range(20, 200);
                choppy         <= 1'($urandom_range(0, 1));
            end else begin
                stall_mode_cnt <= stall_mode_cnt - 1;
            end
            i_stall <= choppy ? ($urandom_range(0, 2) != 0) : 1'b0;
        end
    end

    // monitor: every response word is checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsps.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("unexpected response word %p", o_rsp);
            end else begin
                automatic t_rsp exp_rsp = expected_rsps.pop_front();
                if (o_rsp.found !== exp_rsp.found || o_rsp.slot !== exp_rsp.slot
                        || o_rsp.status !== exp_rsp.status) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display({"mismatch: expected found=%0d slot=%0d status=%0d,",
                                  " got found=%0d slot=%0d status=%0d"},
                                 exp_rsp.found, exp_rsp.slot, exp_rsp.status,
                                 o_rsp.found, o_rsp.slot, o_rsp.status);
                end
            end
        end
    end

    initial begin
        int k;
        i_rst_n      = 1'b0;
        mismatch_cnt = 0;
        stim_done    = 1'b0;
        for (int i = 0; i < TREE_SIZE; i++)
            shadow_tree[i] = 8'd0;

        // directed: empty-tree find, zero key both ways, root, duplicates,
        // extreme keys, and a sorted run that chains down one side to depth limit
        pending_reqs.push_back(mk_req(REQ_FIND, 8'd128));
        pending_reqs.push_back(mk_req(REQ_INSERT, 8'd0));
        pending_reqs.push_back(mk_req(REQ_FIND, 8'd0));
        pending_reqs.push_back(mk_req(REQ_INSERT, 8'd128));
        pending_reqs.push_back(mk_req(REQ_INSERT, 8'd128));
        pending_reqs.push_back(mk_req(REQ_INSERT, 8'd255));
        pending_reqs.push_back(mk_req(REQ_INSERT, 8'd1));
        pending_reqs.push_back(mk_req(REQ_FIND, 8'd255));
        pending_reqs.push_back(mk_req(REQ_FIND, 8'd1));
        pending_reqs.push_back(mk_req(REQ_FIND, 8'd127));
        for (k = 2; k <= 12; k++)   // right chain under 1: runs out of levels
            pending_reqs.push_back(mk_req(REQ_INSERT, k[7:0]));
        pending_reqs.push_back(mk_req(REQ_FIND, 8'd12));
        pending_reqs.push_back(mk_req(REQ_FIND, 8'd10));
        pending_reqs.push_back(mk_req(REQ_INSERT, 8'd10));

        // random: mostly inserts early, then an even mix of inserts and finds
        for (int i = 0; i < N_RANDOM; i++) begin
            automatic logic rtype = (i < 400) ? ($urandom_range(0, 3) == 0)
                                              : ($urandom_range(0, 1) == 1);
            automatic logic [7:0] key = ($urandom_range(0, 40) == 0) ? 8'd0
                                                                      : 8'($urandom_range(0, 255));
            pending_reqs.push_back(mk_req(rtype, key));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || i_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_rsps.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> array_search_tree_insert_find_core.f
design/astf_pkg.sv
design/astf_cell.sv
design/array_search_tree_insert_find_core.sv
design/astf_checker.sv
tb/array_search_tree_insert_find_core_tb.sv
